/* hdl/lzw_pkg.sv */
package lzw_pkg;

	localparam int unsigned FIRST_CODE = 256;
	localparam int unsigned OUT_W      = 12;
	localparam int unsigned EPOCH_W    = 8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_EMIT_MISS,
		ST_EMIT_END
	} lzw_state_t;

	typedef struct packed {
		logic in_ready;
		logic ram_rd;
		logic probe_next;
		logic take_hit;
		logic emit_miss;
		logic emit_end;
		logic clr_step;
		logic clr_done;
	} lzw_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic in_last;
		logic pvalid;
		logic last;
		logic hit;
		logic empty;
		logic out_free;
		logic clr_last;
		logic epoch_max;
	} lzw_stat_t;

endpackage

/* hdl/lzw_if.sv */
interface lzw_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface lzw_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] out_code;
	logic        end_of_stream;

	modport source (output valid, output out_code, output end_of_stream, input ready);
	modport sink (input valid, input out_code, input end_of_stream, output ready);
endinterface

/* hdl/lzw_ram.sv */
module lzw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

/* hdl/lzw_ctrl.sv */
module lzw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  lzw_pkg::lzw_stat_t stat,
	output lzw_pkg::lzw_cmd_t  cmd
);
	import lzw_pkg::*;

	lzw_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					cmd.clr_done = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					if (!stat.pvalid) begin
						state_d = stat.in_last ? ST_EMIT_END : ST_IDLE;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.ram_rd = 1'b1;
				state_d    = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.hit) begin
					cmd.take_hit = 1'b1;
					state_d      = stat.last ? ST_EMIT_END : ST_IDLE;
				end else if (stat.empty) begin
					state_d = ST_EMIT_MISS;
				end else begin
					cmd.probe_next = 1'b1;
					state_d        = ST_READ;
				end
			end
			ST_EMIT_MISS: begin
				if (stat.out_free) begin
					cmd.emit_miss = 1'b1;
					state_d       = stat.last ? ST_EMIT_END : ST_IDLE;
				end
			end
			ST_EMIT_END: begin
				if (stat.out_free) begin
					cmd.emit_end = 1'b1;
					state_d      = stat.epoch_max ? ST_CLEAR : ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// an item is only taken with no lookup in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.in_ready |-> state_q == ST_IDLE)
		else $error("input taken outside idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_hit |-> $past(cmd.ram_rd))
		else $error("hit taken without a read");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_done |=> state_q == ST_IDLE)
		else $error("clear did not end in idle");
endmodule

/* hdl/lzw_dpath.sv */
module lzw_dpath #(
	parameter int unsigned DICT_SIZE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	lzw_in_if.sink             in_ch,
	lzw_out_if.source          out_ch,
	input  lzw_pkg::lzw_cmd_t  cmd,
	output lzw_pkg::lzw_stat_t stat
);
	import lzw_pkg::*;

	localparam int unsigned CW    = $clog2(DICT_SIZE);
	localparam int unsigned DEPTH = 2 ** CW;
	localparam int unsigned EW    = EPOCH_W + CW + 8 + CW;

	logic [7:0]         byte_q;
	logic               last_q;
	logic [CW-1:0]      prefix_q;
	logic               pvalid_q;
	logic [CW:0]        nfree_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      clr_q;
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_code_q;
	logic               out_end_q;

	logic               accept;
	logic [CW-1:0]      hash;
	logic               wr_en;
	logic [CW-1:0]      wr_addr;
	logic [EW-1:0]      wr_data;
	logic [EW-1:0]      rd_data;
	logic [EPOCH_W-1:0] rd_epoch;
	logic [CW-1:0]      rd_prefix;
	logic [7:0]         rd_byte;
	logic [CW-1:0]      rd_code;
	logic               room;

	assign accept      = in_ch.valid && cmd.in_ready;
	assign in_ch.ready = cmd.in_ready;
	assign hash        = prefix_q ^ {in_ch.data_byte, {(CW-8){1'b0}}};
	assign room        = nfree_q < (CW+1)'(DICT_SIZE);

	assign {rd_epoch, rd_prefix, rd_byte, rd_code} = rd_data;

	assign wr_en   = cmd.clr_step || (cmd.emit_miss && room);
	assign wr_addr = cmd.clr_step ? clr_q : idx_q;
	assign wr_data = cmd.clr_step ? '0 : {epoch_q, prefix_q, byte_q, nfree_q[CW-1:0]};

	lzw_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_dict (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.ram_rd),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	always_comb begin
		stat           = '0;
		stat.in_valid  = in_ch.valid;
		stat.in_last   = in_ch.last_byte;
		stat.pvalid    = pvalid_q;
		stat.last      = last_q;
		stat.empty     = rd_epoch != epoch_q;
		stat.hit       = !stat.empty && rd_prefix == prefix_q && rd_byte == byte_q;
		stat.out_free  = !out_valid_q || out_ch.ready;
		stat.clr_last  = clr_q == CW'(DEPTH - 1);
		stat.epoch_max = epoch_q == '1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvalid_q    <= 1'b0;
			prefix_q    <= '0;
			nfree_q     <= (CW+1)'(FIRST_CODE);
			epoch_q     <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.clr_done) begin
				epoch_q <= EPOCH_W'(1);
			end
			if (accept && !pvalid_q) begin
				prefix_q <= CW'(in_ch.data_byte);
				pvalid_q <= 1'b1;
			end
			if (cmd.take_hit) begin
				prefix_q <= rd_code;
			end
			if (cmd.emit_miss) begin
				out_valid_q <= 1'b1;
				prefix_q    <= CW'(byte_q);
				if (room) begin
					nfree_q <= nfree_q + 1'b1;
				end
			end
			if (cmd.emit_end) begin
				out_valid_q <= 1'b1;
				pvalid_q    <= 1'b0;
				prefix_q    <= '0;
				nfree_q     <= (CW+1)'(FIRST_CODE);
				epoch_q     <= epoch_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= in_ch.data_byte;
			last_q <= in_ch.last_byte;
			idx_q  <= hash;
		end
		if (cmd.probe_next) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.emit_miss) begin
			out_code_q <= OUT_W'(prefix_q);
			out_end_q  <= 1'b0;
		end
		if (cmd.emit_end) begin
			out_code_q <= OUT_W'(prefix_q);
			out_end_q  <= 1'b1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.out_code      = out_code_q;
	assign out_ch.end_of_stream = out_end_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_miss || cmd.emit_end) |-> (!out_valid_q || out_ch.ready))
		else $error("pending code overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		nfree_q <= (CW+1)'(DICT_SIZE))
		else $error("free code past dictionary size");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_end |=> !pvalid_q && nfree_q == (CW+1)'(FIRST_CODE))
		else $error("stream end did not restart dictionary");
endmodule

/* hdl/lzw_byte_compressor.sv */
// The first byte of a stream only sets the prefix; later bytes take hashed probes in the
// dictionary RAM, one read each, and a miss adds a step to emit the code. Each code is
// registered and on the output in the cycle after it is formed. A byte is taken only in
// idle. Reset clears control state and starts a pass clearing all 2**clog2(DICT_SIZE)
// dictionary entries; the pass reruns after every 255 streams. No item is taken during it.
module lzw_byte_compressor #(
	parameter int unsigned DICT_SIZE = 4096
) (
	input  logic      clk,
	input  logic      arst_n,
	lzw_in_if.sink    in_ch,
	lzw_out_if.source out_ch
);
	import lzw_pkg::*;

	lzw_cmd_t  cmd;
	lzw_stat_t stat;

	lzw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	lzw_dpath #(
		.DICT_SIZE (DICT_SIZE)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cmd    (cmd),
		.stat   (stat)
	);
endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import lzw_pkg::*;

	localparam int unsigned DICT_LIMIT = 512;
	localparam int unsigned HOLD_CYCLES = 400;

	typedef struct {
		logic [7:0] data;
		logic       last;
		int         phase;
		bit         pause;
	} byte_item_t;

	typedef struct {
		logic [11:0] code;
		logic        eos;
	} code_item_t;

	logic clk;
	logic arst_n;

	lzw_in_if  in_if ();
	lzw_out_if out_if ();

	lzw_byte_compressor #(.DICT_SIZE(DICT_LIMIT)) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_if.sink),
		.out_ch(out_if.source)
	);

	byte_item_t  pending_q[$];
	code_item_t  code_q[$];
	int          err_cnt;
	logic        in_fired;
	int unsigned src_idle;
	int unsigned snk_idle;
	bit          hold_go;
	bit          hold_done;
	int unsigned hold_cnt;

	// compressor state
	logic [11:0] dict_code[bit [19:0]];
	logic [11:0] cur_prefix;
	bit          have_prefix;
	int unsigned free_code;

	function automatic void compress_byte(logic [7:0] b, logic l);
		code_item_t r;
		if (!have_prefix) begin
			cur_prefix  = {4'd0, b};
			have_prefix = 1;
		end else if (dict_code.exists({cur_prefix, b})) begin
			cur_prefix = dict_code[{cur_prefix, b}];
		end else begin
			r.code = cur_prefix;
			r.eos  = 1'b0;
			code_q.push_back(r);
			if (free_code < DICT_LIMIT) begin
				dict_code[{cur_prefix, b}] = free_code[11:0];
				free_code++;
			end
			cur_prefix = {4'd0, b};
		end
		if (l) begin
			r.code = cur_prefix;
			r.eos  = 1'b1;
			code_q.push_back(r);
			have_prefix = 0;
			cur_prefix  = '0;
			free_code   = FIRST_CODE;
			dict_code.delete();
		end
	endfunction

	function automatic void add_byte(logic [7:0] b, logic l, int ph, bit pause);
		byte_item_t it;
		it.data  = b;
		it.last  = l;
		it.phase = ph;
		it.pause = pause;
		pending_q.push_back(it);
	endfunction

	// random stream; narrow alphabets give long dictionary hits
	function automatic void add_stream(int len, int ph, bit pause);
		logic [7:0] alpha[4];
		bit         narrow;
		narrow = ($urandom_range(99) < 70);
		foreach (alpha[k]) alpha[k] = 8'($urandom);
		for (int k = 0; k < len; k++)
			add_byte(narrow ? alpha[$urandom_range(3)] : 8'($urandom), k == len - 1,
				ph, pause && k == 0);
	endfunction

	function automatic void add_phase(int ph, bit pause);
		int n;
		n = 0;
		while (n < 250) begin
			int len;
			len = $urandom_range(1, 30);
			add_stream(len, ph, pause && n == 0);
			n += len;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#15ms;
		$display("Verification failed");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_fired <= 1'b0;
		end else begin
			in_fired <= in_if.valid && in_if.ready;
			if (out_if.valid && out_if.ready) begin
				if (code_q.size() == 0) begin
					$display("%0t: unexpected code %0d eos %0b", $time,
						out_if.out_code, out_if.end_of_stream);
					err_cnt++;
				end else begin
					code_item_t e;
					e = code_q.pop_front();
					if (e.code !== out_if.out_code || e.eos !== out_if.end_of_stream) begin
						$display("%0t: expected code %0d eos %0b, got code %0d eos %0b",
							$time, e.code, e.eos, out_if.out_code, out_if.end_of_stream);
						err_cnt++;
					end
				end
			end
			if (in_if.valid && in_if.ready)
				compress_byte(in_if.data_byte, in_if.last_byte);
		end
	end

	// sender
	always @(negedge clk) begin
		if (arst_n && (!in_if.valid || in_fired)) begin
			logic nv;
			nv = 1'b0;
			if (pending_q.size() != 0) begin
				if (pending_q[0].pause && (code_q.size() != 0 || in_fired)) begin
					nv = 1'b0;
				end else if ($urandom_range(99) < src_idle && !pending_q[0].pause) begin
					nv = 1'b0;
				end else begin
					byte_item_t it;
					it = pending_q.pop_front();
					case (it.phase)
						0: begin
							src_idle = 14;
							snk_idle <= 85;
						end
						1: begin
							src_idle = 85;
							snk_idle <= 14;
						end
						default: begin
							src_idle = 0;
							snk_idle <= 0;
							if (it.pause) hold_go <= 1'b1;
						end
					endcase
					in_if.data_byte <= it.data;
					in_if.last_byte <= it.last;
					nv = 1'b1;
				end
			end
			in_if.valid <= nv;
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_if.ready <= 1'b0;
			end else if (hold_go && !hold_done) begin
				hold_cnt  = HOLD_CYCLES;
				hold_done = 1;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= ($urandom_range(99) >= snk_idle);
			end
		end
	end

	initial begin
		logic [7:0] fill;
		err_cnt         = 0;
		src_idle        = 14;
		snk_idle        = 85;
		hold_go         = 0;
		hold_done       = 0;
		hold_cnt        = 0;
		have_prefix     = 0;
		cur_prefix      = '0;
		free_code       = FIRST_CODE;
		in_if.valid     = 1'b0;
		in_if.data_byte = '0;
		in_if.last_byte = 1'b0;
		out_if.ready    = 1'b0;
		arst_n          = 1'b0;

		// single-byte streams at the extremes
		add_byte(8'hFF, 1'b1, 0, 1'b0);
		add_byte(8'h00, 1'b1, 0, 1'b0);
		// alternating pattern: repeated pairs hit the dictionary
		for (int k = 0; k < 10; k++) add_byte(k[0] ? 8'hFF : 8'h00, k == 9, 0, 1'b0);
		// long run of one byte builds chained entries
		for (int k = 0; k < 12; k++) add_byte(8'h55, k == 11, 0, 1'b0);
		add_byte(8'hAA, 1'b0, 0, 1'b0);
		add_byte(8'hAA, 1'b1, 0, 1'b0);
		add_phase(0, 1'b0);
		add_phase(1, 1'b1);
		add_phase(2, 1'b1);
		// random stream long enough to fill the dictionary and run past it
		for (int k = 0; k < 400; k++) begin
			fill = 8'($urandom);
			add_byte(fill, k == 399, 2, 1'b0);
		end
		add_stream(20, 2, 1'b0);

		repeat (5) @(posedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || in_if.valid) @(posedge clk);
		while (code_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (err_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
